// ===== rtl/rgba8_texture_tiler_top_defines.svh =====
// Assertion helpers shared by the tiler RTL.
`ifndef RGBA8_TEXTURE_TILER_TOP_DEFINES_SVH
`define RGBA8_TEXTURE_TILER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtt: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define RTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtt: next-cycle check failed");

`endif

// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int CFG_W          = 11;
    localparam int ROW_W          = 10;
    localparam int PAIRS_PER_TILE = 32;
    localparam int PAIR_W         = $clog2(PAIRS_PER_TILE);
    localparam int TQ_DEPTH       = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // configuration register indexes
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // one band store word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    // back end tells the front a tile no longer needs the band store
    typedef struct packed {
        logic valid;
        logic parity;
    } tile_done_t;

endpackage

// ===== rtl/rtt_front.sv =====
module rtt_front import rtt_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W    = ($clog2(MAX_WIDTH) < 3) ? 3 : $clog2(MAX_WIDTH),
    localparam int TD_W     = COL_W - 1,
    localparam int ADDR_W   = COL_W + 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output pixel_t            wr_data,
    output logic              q_push,
    output logic [TD_W-1:0]   q_data,
    input  logic              q_full,
    input  tile_done_t        done
);

    localparam int EW_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int OC_W = $clog2(TQ_DEPTH + 2);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [OC_W-1:0]  busy_reg [2];
    logic [OC_W-1:0]  busy_next [2];

    logic [EW_W-1:0]  w_ext, eff_w;
    logic [CFG_W-1:0] eff_h;
    logic             col_end, row_end;
    logic             band_start, tile_hit, parity, blocked, accept;

    // effective frame size: zero acts as one, oversize saturates
    always_comb begin
        w_ext = EW_W'(width_reg);
        if (w_ext == '0) begin
            eff_w = EW_W'(1);
        end else if (w_ext > EW_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        if (height_reg == '0) begin
            eff_h = CFG_W'(1);
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
    end

    assign col_end = (EW_W'(col_reg) + EW_W'(1)) >= eff_w;
    assign row_end = (CFG_W'(row_reg) + CFG_W'(1)) >= eff_h;

    // position classification; bit 2 of the row picks the band half
    assign parity     = row_reg[2];
    assign band_start = (col_reg == '0) && (row_reg[1:0] == 2'b00);
    assign tile_hit   = (&col_reg[1:0]) && (&row_reg[1:0]);

    // hold off a new band while its half still has tiles in flight, or a tile end on a full queue
    assign blocked  = (band_start && (busy_reg[parity] != '0)) || (tile_hit && q_full);
    assign s_tready = aresetn && !blocked;
    assign accept   = s_tvalid && s_tready;

    // band store write
    assign wr_en   = accept;
    assign wr_addr = {parity, row_reg[1:0], col_reg};
    always_comb begin
        wr_data.red   = s_tdata[7:0];
        wr_data.green = s_tdata[15:8];
        wr_data.blue  = s_tdata[23:16];
        wr_data.alpha = s_tdata[31:24];
    end

    // tile descriptor: band half and column of the tile
    assign q_push = accept && tile_hit;
    assign q_data = {parity, col_reg[COL_W-1:2]};

    // tiles outstanding per band half
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            busy_next[p] = busy_reg[p];
            if (q_push && (parity == p[0])) begin
                busy_next[p] = busy_next[p] + OC_W'(1);
            end
            if (done.valid && (done.parity == p[0])) begin
                busy_next[p] = busy_next[p] - OC_W'(1);
            end
        end
    end

    // raster position advance
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            busy_reg[0] <= '0;
            busy_reg[1] <= '0;
        end else begin
            busy_reg[0] <= busy_next[0];
            busy_reg[1] <= busy_next[1];
            if (cfg_wr_en) begin
                // any register write restarts the frame
                unique case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default:          width_reg  <= width_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== rtl/rtt_tile_fifo.sv =====
module rtt_tile_fifo import rtt_pkg::*; #(
    parameter int WIDTH = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = $clog2(TQ_DEPTH);

    logic [WIDTH-1:0] slot_reg [TQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (PTR_W + 1)'(TQ_DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (PTR_W + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (PTR_W + 1)'(1);
        end
    end

    // descriptor storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ===== rtl/rtt_back.sv =====
module rtt_back import rtt_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W    = ($clog2(MAX_WIDTH) < 3) ? 3 : $clog2(MAX_WIDTH),
    localparam int TD_W     = COL_W - 1,
    localparam int ADDR_W   = COL_W + 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_data,
    input  logic              q_empty,
    input  logic [TD_W-1:0]   q_data,
    output logic              q_pop,
    output tile_done_t        done,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } bk_state_t;

    bk_state_t         state_reg, state_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [TD_W-1:0]   tile_reg, tile_next;

    pixel_t            band_mem [MEM_DEPTH];
    pixel_t            rd_data_reg;
    logic              d_valid_reg, d_plane_reg, d_last_reg;
    logic              m_valid_reg, m_last_reg, m_plane_reg;
    logic [7:0]        m_first_reg, m_second_reg;

    logic              issue, d_move, last_pair;
    logic [ADDR_W-1:0] rd_addr;

    // read a pair only when the data stage will have room for it
    assign d_move    = d_valid_reg && (!m_valid_reg || m_tready);
    assign issue     = (state_reg == BK_RUN) && (!d_valid_reg || d_move);
    assign last_pair = pair_reg == PAIR_W'(PAIRS_PER_TILE - 1);

    // band half, tile row, tile column, pixel column
    assign rd_addr = {tile_reg[TD_W-1], pair_reg[3:2], tile_reg[TD_W-2:0], pair_reg[1:0]};

    assign done.valid  = issue && last_pair;
    assign done.parity = tile_reg[TD_W-1];

    // tile sequencer
    always_comb begin
        state_next = state_reg;
        pair_next  = pair_reg;
        tile_next  = tile_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    tile_next  = q_data;
                    pair_next  = '0;
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (issue) begin
                    pair_next = pair_reg + PAIR_W'(1);
                    if (last_pair) begin
                        if (!q_empty) begin
                            q_pop     = 1'b1;
                            tile_next = q_data;
                        end else begin
                            state_next = BK_IDLE;
                        end
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // band store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            band_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= band_mem[rd_addr];
            d_plane_reg <= pair_reg[PAIR_W-1];
            d_last_reg  <= last_pair;
        end
        if (d_move) begin
            m_first_reg  <= d_plane_reg ? rd_data_reg.green : rd_data_reg.alpha;
            m_second_reg <= d_plane_reg ? rd_data_reg.blue  : rd_data_reg.red;
            m_plane_reg  <= d_plane_reg;
            m_last_reg   <= d_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            pair_reg    <= '0;
            tile_reg    <= '0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
            tile_reg  <= tile_next;
            if (issue) begin
                d_valid_reg <= 1'b1;
            end else if (d_move) begin
                d_valid_reg <= 1'b0;
            end
            if (d_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_second_reg, m_first_reg};
    assign m_tuser  = m_plane_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/rgba8_texture_tiler_top.sv =====
// RGBA8 4x4 texture tiler. Raster pixels enter one word per cycle and are written into a
// double-buffered band store (two halves of four rows each). The pixel that closes a 4x4 tile
// in the fourth row of a band queues that tile; the back end then reads the band store one
// pixel per cycle while m_tready allows and sends 32 words: 16 alpha/red pairs, then 16
// green/blue pairs, each in row-major order, the last one marked with m_tlast. Over full
// bands the sustained rate is set by the single band store read port. The input stalls at
// a tile-closing pixel while the tile queue is full, and at the first pixel of a band while
// tiles of the earlier band in the same store half are still being read out. Columns and
// rows past the last multiple of four are stored but never sent. A write to either size
// register restarts the frame at row 0, column 0. No clearing pass after reset.
`include "rgba8_texture_tiler_top_defines.svh"

module rgba8_texture_tiler_top import rtt_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // first_byte[7:0], second_byte[15:8]
    output logic             m_tuser,   // plane
    output logic             m_tlast    // tile_last
);

    localparam int COL_W  = ($clog2(MAX_WIDTH) < 3) ? 3 : $clog2(MAX_WIDTH);
    localparam int TD_W   = COL_W - 1;
    localparam int ADDR_W = COL_W + 3;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pixel_t            wr_data;
    logic              q_push, q_full, q_pop, q_empty;
    logic [TD_W-1:0]   q_din, q_dout;
    tile_done_t        done;

    rtt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_push    (q_push),
        .q_data    (q_din),
        .q_full    (q_full),
        .done      (done)
    );

    rtt_tile_fifo #(.WIDTH(TD_W)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    rtt_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .q_empty  (q_empty),
        .q_data   (q_dout),
        .q_pop    (q_pop),
        .done     (done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // the closing word of a tile always belongs to the green/blue half
    `RTT_ASSERT_NOW(a_last_in_plane1, m_tvalid && m_tlast, m_tuser)
    // the front never queues a tile into a full queue
    `RTT_ASSERT_NOW(a_no_push_full, q_push, !q_full)
    // the back end only takes descriptors that exist
    `RTT_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty)
    // a queued tile not taken at once is still there next cycle
    `RTT_ASSERT_NEXT(a_push_holds, q_push && !q_pop, !q_empty)

endmodule
